// File: sv/bdg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdg_pkg
// Types and constants shared by the button debounce and gesture detector.
// ----------------------------------------------------------------------------
package bdg_pkg;

	localparam int unsigned TimeW   = 32;
	localparam int unsigned MsW     = 16;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 40;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_CLICK  = 3'd1,
		EV_DOUBLE = 3'd2,
		EV_LONG   = 3'd3,
		EV_TICK   = 3'd4
	} ev_t;

	typedef enum logic [2:0] {
		GS_IDLE   = 3'd0,
		GS_PRESS  = 3'd1,
		GS_REL1   = 3'd2,
		GS_PRESS2 = 3'd3,
		GS_LONG   = 3'd4
	} gst_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DEBOUNCE = 3'd0,
		REG_CLICK    = 3'd1,
		REG_PRESS    = 3'd2,
		REG_RETICK   = 3'd3,
		REG_ACT_LOW  = 3'd4,
		REG_DBL_ON   = 3'd5,
		REG_TICK_ON  = 3'd6
	} reg_idx_t;

	localparam logic [MsW-1:0] DebounceRst = 16'd10;
	localparam logic [MsW-1:0] ClickRst    = 16'd300;
	localparam logic [MsW-1:0] PressRst    = 16'd1000;
	localparam logic [MsW-1:0] RetickRst   = 16'd200;

	typedef struct packed {
		logic [MsW-1:0] debounce_ms;
		logic [MsW-1:0] click_ms;
		logic [MsW-1:0] press_ms;
		logic [MsW-1:0] retick_ms;
		logic           active_low;
		logic           double_click_on;
		logic           retick_on;
	} cfg_t;

	// preset of the stable level on a polarity write
	typedef struct packed {
		logic en;
		logic level;
	} preset_t;

endpackage
`default_nettype wire

// File: sv/bdg_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdg_cfg
// Configuration register file with polarity preset strobe.
// ----------------------------------------------------------------------------
module bdg_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [bdg_pkg::CfgIdxW-1:0]  cfg_idx,
	input  wire logic [bdg_pkg::MsW-1:0]      cfg_wdata,
	output bdg_pkg::cfg_t                     cfg,
	output bdg_pkg::preset_t                  preset
);

	bdg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= bdg_pkg::DebounceRst;
			cfg_q.click_ms        <= bdg_pkg::ClickRst;
			cfg_q.press_ms        <= bdg_pkg::PressRst;
			cfg_q.retick_ms       <= bdg_pkg::RetickRst;
			cfg_q.active_low      <= 1'b0;
			cfg_q.double_click_on <= 1'b0;
			cfg_q.retick_on       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				bdg_pkg::REG_DEBOUNCE: cfg_q.debounce_ms     <= cfg_wdata;
				bdg_pkg::REG_CLICK:    cfg_q.click_ms        <= cfg_wdata;
				bdg_pkg::REG_PRESS:    cfg_q.press_ms        <= cfg_wdata;
				bdg_pkg::REG_RETICK:   cfg_q.retick_ms       <= cfg_wdata;
				bdg_pkg::REG_ACT_LOW:  cfg_q.active_low      <= cfg_wdata[0];
				bdg_pkg::REG_DBL_ON:   cfg_q.double_click_on <= cfg_wdata[0];
				bdg_pkg::REG_TICK_ON:  cfg_q.retick_on       <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg          = cfg_q;
	assign preset.en    = cfg_we && (cfg_idx == bdg_pkg::REG_ACT_LOW);
	assign preset.level = cfg_wdata[0];

endmodule
`default_nettype wire

// File: sv/bdg_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdg_core
// Debounce and gesture state with the result register.
// ----------------------------------------------------------------------------
module bdg_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bdg_pkg::cfg_t               cfg,
	input  wire bdg_pkg::preset_t            preset,
	input  wire logic                        in_valid,
	input  wire logic                        raw_level,
	input  wire logic [bdg_pkg::TimeW-1:0]   now_ms,
	output logic                             adv,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output bdg_pkg::ev_t                     event_res,
	output logic                             pressed,
	output logic [bdg_pkg::TimeW-1:0]        hold_ms
);

	logic                      last_raw_q;
	logic                      stable_q;
	logic [bdg_pkg::TimeW-1:0] mark_q;
	bdg_pkg::gst_t             gst_q;
	logic [bdg_pkg::TimeW-1:0] pstart_q;
	logic [bdg_pkg::TimeW-1:0] tick_q;

	logic                      out_valid_q;
	bdg_pkg::ev_t              ev_q;
	logic                      pressed_q;
	logic [bdg_pkg::TimeW-1:0] hold_q;

	logic                      raw_chg;
	logic [bdg_pkg::TimeW-1:0] dt_mark;
	logic [bdg_pkg::TimeW-1:0] dt_gest;
	logic [bdg_pkg::TimeW-1:0] dt_tick;
	logic                      deb_ok;
	logic                      stable_d;
	logic                      act;
	logic [bdg_pkg::TimeW-1:0] pstart_d;
	logic [bdg_pkg::TimeW-1:0] mark_d;
	logic [bdg_pkg::TimeW-1:0] tick_d;
	bdg_pkg::gst_t             gst_d;
	bdg_pkg::ev_t              ev_d;

	assign adv = in_valid && (!out_valid_q || out_ready);

	always_comb begin
		raw_chg  = raw_level != last_raw_q;
		dt_mark  = now_ms - mark_q;
		deb_ok   = !raw_chg && (dt_mark >= {16'd0, cfg.debounce_ms});
		stable_d = stable_q;
		pstart_d = pstart_q;
		if (deb_ok && (raw_level != stable_q)) begin
			stable_d = raw_level;
			if (raw_level ^ cfg.active_low)
				pstart_d = now_ms;
		end
		act     = stable_d ^ cfg.active_low;
		mark_d  = raw_chg ? now_ms : mark_q;
		dt_gest = raw_chg ? '0 : dt_mark;
		dt_tick = now_ms - tick_q;
		tick_d  = tick_q;
		gst_d   = gst_q;
		ev_d    = bdg_pkg::EV_NONE;
		case (gst_q)
			bdg_pkg::GS_PRESS: begin
				if (!act) begin
					gst_d = bdg_pkg::GS_REL1;
				end else if (dt_gest > {16'd0, cfg.press_ms}) begin
					ev_d  = bdg_pkg::EV_LONG;
					gst_d = bdg_pkg::GS_LONG;
				end
			end
			bdg_pkg::GS_REL1: begin
				if ((dt_gest > {16'd0, cfg.click_ms}) || (!act && !cfg.double_click_on)) begin
					ev_d  = bdg_pkg::EV_CLICK;
					gst_d = bdg_pkg::GS_IDLE;
				end else if (act) begin
					gst_d = bdg_pkg::GS_PRESS2;
				end
			end
			bdg_pkg::GS_PRESS2: begin
				if (!act) begin
					if (cfg.double_click_on)
						ev_d = bdg_pkg::EV_DOUBLE;
					gst_d = bdg_pkg::GS_IDLE;
				end
			end
			bdg_pkg::GS_LONG: begin
				if (!act) begin
					gst_d = bdg_pkg::GS_IDLE;
				end else if (cfg.retick_on && (dt_tick > {16'd0, cfg.retick_ms})) begin
					ev_d   = bdg_pkg::EV_TICK;
					tick_d = now_ms;
				end
			end
			default: begin
				if (act) begin
					gst_d  = bdg_pkg::GS_PRESS;
					mark_d = now_ms;
				end else begin
					gst_d = bdg_pkg::GS_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q <= 1'b0;
			stable_q   <= 1'b0;
			mark_q     <= '0;
			gst_q      <= bdg_pkg::GS_IDLE;
			pstart_q   <= '0;
			tick_q     <= '0;
		end else if (preset.en) begin
			stable_q <= preset.level;
		end else if (adv) begin
			last_raw_q <= raw_level;
			stable_q   <= stable_d;
			mark_q     <= mark_d;
			gst_q      <= gst_d;
			pstart_q   <= pstart_d;
			tick_q     <= tick_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_q      <= ev_d;
			pressed_q <= act;
			hold_q    <= act ? (now_ms - pstart_d) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = ev_q;
	assign pressed   = pressed_q;
	assign hold_ms   = hold_q;

endmodule
`default_nettype wire

// File: sv/button_debounce_gesture_detector_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_gesture_detector_top
// Button debouncer with click, double click, long press and tick reporting.
// ----------------------------------------------------------------------------
// Each input transfer carries a raw pin level and the millisecond time; each
// one yields exactly one output transfer with the event, the debounced active
// level and the hold time. Items pass the input register, then debounce and
// gesture logic into the result register, and one item is taken
// every cycle; the result register frees as soon as it is taken, so the input
// stalls only while a result waits. Configuration writes take effect at once
// and are meant for when no transfer is in flight; writing the polarity also
// presets the debounced level to the inactive level.
// ----------------------------------------------------------------------------
module button_debounce_gesture_detector_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [bdg_pkg::InDataW-1:0]     s_tdata,   // raw_level, now_ms[31:0], pad
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [bdg_pkg::OutDataW-1:0]         m_tdata,   // event_res[2:0], pressed, hold_ms, pad
	input  wire logic                            cfg_we,
	input  wire logic [bdg_pkg::CfgIdxW-1:0]     cfg_idx,
	input  wire logic [bdg_pkg::MsW-1:0]         cfg_wdata
);

	bdg_pkg::cfg_t             cfg;
	bdg_pkg::preset_t          preset;
	logic                      valid_s1;
	logic                      raw_s1;
	logic [bdg_pkg::TimeW-1:0] now_s1;
	logic                      adv;
	bdg_pkg::ev_t              event_res;
	logic                      pressed;
	logic [bdg_pkg::TimeW-1:0] hold_ms;

	bdg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.preset    (preset)
	);

	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			raw_s1 <= s_tdata[0];
			now_s1 <= s_tdata[32:1];
		end
	end

	bdg_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.preset    (preset),
		.in_valid  (valid_s1),
		.raw_level (raw_s1),
		.now_ms    (now_s1),
		.adv       (adv),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.event_res (event_res),
		.pressed   (pressed),
		.hold_ms   (hold_ms)
	);

	assign m_tdata = {4'd0, hold_ms, pressed, event_res};

	a_hold_zero_released: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !pressed |-> hold_ms == '0)
		else $error("hold time nonzero while released");

	a_held_events_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (event_res == bdg_pkg::EV_LONG || event_res == bdg_pkg::EV_TICK)
		|-> pressed)
		else $error("long press or tick reported while released");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("processed item produced no result");

endmodule
`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button debounce and gesture detector.
// ----------------------------------------------------------------------------
// Raw level and time samples are streamed in with random gaps while the
// result side stalls at random. A local predictor follows each accepted
// sample and queues the expected event, pressed level and hold time; every
// result transfer is checked against the oldest entry. Directed sequences
// cover click, double click, long press with ticks, glitches and time wrap;
// random phases then run gestures and stray samples under varied settings.
// ----------------------------------------------------------------------------
module tb;
	import bdg_pkg::*;

	localparam int unsigned CycleLimit = 300000;
	localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

	typedef struct packed {
		ev_t              ev;
		logic             pressed;
		logic [TimeW-1:0] hold_ms;
	} gesture_res_t;

	typedef enum int {PH_TYPICAL, PH_ZERO, PH_MAX} phase_kind_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	wire                 s_tready;
	logic [InDataW-1:0]  s_tdata   = '0;
	wire                 m_tvalid;
	logic                m_tready  = 1'b0;
	wire [OutDataW-1:0]  m_tdata;
	logic                cfg_we    = 1'b0;
	logic [CfgIdxW-1:0]  cfg_idx   = '0;
	logic [MsW-1:0]      cfg_wdata = '0;

	button_debounce_gesture_detector_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // raw_level, now_ms[31:0], pad
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // event_res[2:0], pressed, hold_ms, pad
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state
	cfg_t             cur_cfg;
	logic             raw_prev;
	logic             level_db;
	logic [TimeW-1:0] stamp_ms;
	gst_t             gst;
	logic [TimeW-1:0] press_t0;
	logic [TimeW-1:0] tick_t0;

	gesture_res_t     expected_res[$];
	logic [TimeW-1:0] clock_ms = '0;

	bit               gaps_on    = 1'b1;
	int unsigned      sink_hold  = 0;
	int unsigned      ready_run  = 0;
	int unsigned      cycle_cnt  = 0;
	int unsigned      errors     = 0;
	int unsigned      reported   = 0;
	int unsigned      items_sent = 0;
	int unsigned      results_seen = 0;
	int unsigned      cfg_writes = 0;
	int unsigned      ev_count [0:4] = '{default: 0};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				expected_res.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side ready with random stalls; sink_hold forces a long hold-off
	always @(posedge clk) begin : sink_ctrl
		int unsigned pick;
		if (sink_hold != 0) begin
			m_tready <= 1'b0;
			sink_hold--;
		end else if (!gaps_on) begin
			m_tready <= 1'b1;
			ready_run = 0;
		end else if (ready_run != 0) begin
			ready_run--;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				m_tready <= 1'b1;
				ready_run = $urandom_range(0, 6);
			end else if (pick < 95) begin
				m_tready <= 1'b0;
				ready_run = $urandom_range(0, 3);
			end else begin
				m_tready <= 1'b0;
				ready_run = $urandom_range(10, 40);
			end
		end
	end

	always @(posedge clk) begin : result_check
		gesture_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_res.size() == 0) begin
				errors++;
				if (reported < 10)
					$display("unexpected result transfer, tdata %h", m_tdata);
				reported++;
			end else begin
				want = expected_res.pop_front();
				ev_count[want.ev]++;
				if (m_tdata[2:0] !== want.ev || m_tdata[3] !== want.pressed ||
						m_tdata[TimeW+3:4] !== want.hold_ms) begin
					errors++;
					if (reported < 10)
						$display("result %0d: event %0d/%0d pressed %0b/%0b hold %0d/%0d (exp/got)",
							results_seen, want.ev, m_tdata[2:0], want.pressed, m_tdata[3],
							want.hold_ms, m_tdata[TimeW+3:4]);
					reported++;
				end
			end
		end
	end

	function automatic void predict_gesture(input logic raw, input logic [TimeW-1:0] now);
		gesture_res_t     res;
		logic             act;
		logic [TimeW-1:0] dt;
		res.ev = EV_NONE;
		dt = now - stamp_ms;
		if (raw != raw_prev) begin
			stamp_ms = now;
		end else if (dt >= {16'd0, cur_cfg.debounce_ms}) begin
			if (raw != level_db) begin
				level_db = raw;
				if (level_db ^ cur_cfg.active_low)
					press_t0 = now;
			end
		end
		raw_prev = raw;
		act = level_db ^ cur_cfg.active_low;
		dt = now - stamp_ms;
		case (gst)
			GS_PRESS: begin
				if (!act) begin
					gst = GS_REL1;
				end else if (dt > {16'd0, cur_cfg.press_ms}) begin
					res.ev = EV_LONG;
					gst = GS_LONG;
				end
			end
			GS_REL1: begin
				if (dt > {16'd0, cur_cfg.click_ms} || (!act && !cur_cfg.double_click_on)) begin
					res.ev = EV_CLICK;
					gst = GS_IDLE;
				end else if (act) begin
					gst = GS_PRESS2;
				end
			end
			GS_PRESS2: begin
				if (!act) begin
					if (cur_cfg.double_click_on)
						res.ev = EV_DOUBLE;
					gst = GS_IDLE;
				end
			end
			GS_LONG: begin
				if (!act) begin
					gst = GS_IDLE;
				end else if (cur_cfg.retick_on && (now - tick_t0) > {16'd0, cur_cfg.retick_ms}) begin
					res.ev = EV_TICK;
					tick_t0 = now;
				end
			end
			default: begin
				if (act) begin
					gst = GS_PRESS;
					stamp_ms = now;
				end else begin
					gst = GS_IDLE;
				end
			end
		endcase
		res.pressed = act;
		res.hold_ms = act ? now - press_t0 : '0;
		expected_res.push_back(res);
	endfunction

	task automatic send_item(input logic raw, input logic [TimeW-1:0] now);
		int unsigned gap;
		int unsigned pick;
		gap = 0;
		if (gaps_on) begin
			pick = $urandom_range(0, 99);
			if (pick >= 92)
				gap = $urandom_range(10, 40);
			else if (pick >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(InDataW-TimeW-1){1'b0}}, now, raw};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		predict_gesture(raw, now);
	endtask

	task automatic hold_level(input logic pressed, input int unsigned n,
			input logic [TimeW-1:0] step);
		repeat (n) begin
			clock_ms += step;
			send_item(pressed ^ cur_cfg.active_low, clock_ms);
		end
	endtask

	// wait until every result is back, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_res.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MsW-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
		case (idx)
			REG_DEBOUNCE: cur_cfg.debounce_ms = val;
			REG_CLICK:    cur_cfg.click_ms = val;
			REG_PRESS:    cur_cfg.press_ms = val;
			REG_RETICK:   cur_cfg.retick_ms = val;
			REG_ACT_LOW: begin
				cur_cfg.active_low = val[0];
				level_db = val[0];
			end
			REG_DBL_ON:   cur_cfg.double_click_on = val[0];
			REG_TICK_ON:  cur_cfg.retick_on = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [MsW-1:0] deb, input logic [MsW-1:0] clk_w,
			input logic [MsW-1:0] prs, input logic [MsW-1:0] rtk, input logic al,
			input logic dbl, input logic tick);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_CLICK, clk_w);
		write_reg(REG_PRESS, prs);
		write_reg(REG_RETICK, rtk);
		write_reg(REG_ACT_LOW, {15'd0, al});
		write_reg(REG_DBL_ON, {15'd0, dbl});
		write_reg(REG_TICK_ON, {15'd0, tick});
	endtask

	task automatic test_click_and_wrap();
		send_item(1'b0, '0);
		clock_ms = '1;
		send_item(1'b0, clock_ms);
		// press and release across the time wrap
		hold_level(1'b1, 2, 20);
		hold_level(1'b0, 3, 20);
	endtask

	task automatic test_double_click();
		drain();
		write_reg(REG_DBL_ON, 16'd1);
		hold_level(1'b1, 2, 20);
		hold_level(1'b0, 2, 20);
		hold_level(1'b1, 2, 20);
		hold_level(1'b0, 2, 20);
		// switched off while waiting for a second press: click on next sample
		hold_level(1'b1, 2, 20);
		hold_level(1'b0, 2, 20);
		drain();
		write_reg(REG_DBL_ON, 16'd0);
		hold_level(1'b0, 1, 20);
		// second press taken, then switched off: release gives no event
		drain();
		write_reg(REG_DBL_ON, 16'd1);
		hold_level(1'b1, 2, 20);
		hold_level(1'b0, 2, 20);
		hold_level(1'b1, 2, 20);
		drain();
		write_reg(REG_DBL_ON, 16'd0);
		hold_level(1'b0, 2, 20);
	endtask

	task automatic test_long_press_ticks();
		drain();
		write_reg(REG_PRESS, 16'd50);
		write_reg(REG_RETICK, 16'd30);
		write_reg(REG_TICK_ON, 16'd1);
		write_reg(RegUnused, 16'hFFFF);
		hold_level(1'b1, 2, 20);
		// short glitch restarts the shared timer
		hold_level(1'b0, 1, 5);
		hold_level(1'b1, 4, 30);
		hold_level(1'b0, 2, 20);
	endtask

	task automatic test_backpressure();
		drain();
		gaps_on = 1'b0;
		sink_hold = 200;
		hold_level(1'b1, 12, 7);
		hold_level(1'b0, 12, 7);
		drain();
		gaps_on = 1'b1;
	endtask

	task automatic run_phase(input phase_kind_t kind, input int unsigned n_items,
			input bit with_gaps);
		logic [MsW-1:0]   deb, clk_w, prs, rtk;
		logic [TimeW-1:0] total, step;
		int unsigned      sent, seg_n, pick;
		logic             lvl;
		drain();
		gaps_on = with_gaps;
		case (kind)
			PH_ZERO: set_config('0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
			PH_MAX:  set_config('1, '1, '1, '1, 1'b1, 1'b1, 1'b1);
			default: set_config(16'($urandom_range(0, 20)), 16'($urandom_range(20, 200)),
				16'($urandom_range(60, 400)), 16'($urandom_range(0, 80)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		endcase
		deb = cur_cfg.debounce_ms;
		clk_w = cur_cfg.click_ms;
		prs = cur_cfg.press_ms;
		rtk = cur_cfg.retick_ms;
		clock_ms = $urandom();
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 8) begin
				// stray sample at an arbitrary time
				send_item(1'($urandom_range(0, 1)), $urandom());
				sent++;
			end else begin
				lvl = 1'($urandom_range(0, 1));
				pick = $urandom_range(0, 9);
				if (pick < 2)
					total = $urandom_range(0, deb);
				else if (pick < 7)
					total = deb + $urandom_range(0, clk_w);
				else
					total = deb + prs + $urandom_range(0, 4 * rtk + 10);
				seg_n = $urandom_range(1, 6);
				step = total / seg_n + $urandom_range(0, 2);
				hold_level(lvl, seg_n, step);
				sent += seg_n;
			end
		end
	endtask

	task automatic test_random_gestures();
		run_phase(PH_ZERO, 40, 1'b1);
		repeat (5) run_phase(PH_TYPICAL, 50, 1'b1);
		run_phase(PH_TYPICAL, 40, 1'b0);
		run_phase(PH_MAX, 40, 1'b1);
		run_phase(PH_TYPICAL, 40, 1'b1);
	endtask

	initial begin
		cur_cfg = '{debounce_ms: DebounceRst, click_ms: ClickRst, press_ms: PressRst,
			retick_ms: RetickRst, active_low: 1'b0, double_click_on: 1'b0, retick_on: 1'b0};
		raw_prev = 1'b0;
		level_db = 1'b0;
		stamp_ms = '0;
		gst = GS_IDLE;
		press_t0 = '0;
		tick_t0 = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_click_and_wrap();
		test_double_click();
		test_long_press_ticks();
		test_backpressure();
		test_random_gestures();
		drain();
		repeat (8) @(posedge clk);
		$display("Ran %0d samples, checked %0d results, %0d register writes.",
			items_sent, results_seen, cfg_writes);
		$display("Events: %0d click, %0d double, %0d long press, %0d tick; %0d mismatches.",
			ev_count[1], ev_count[2], ev_count[3], ev_count[4], errors);
		if (errors == 0 && expected_res.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
